// ===== design/crc8sfp_pkg.sv =====
// crc8sfp_pkg: types, constants and the crc-8 byte update for the sensor frame parser
// no dependencies; imported by crc8_checked_sensor_frame_parser
package crc8sfp_pkg;

	localparam logic [7:0] START_BYTE  = 8'h3A;
	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [7:0] FLAG_RAIN   = 8'h81;
	localparam logic [7:0] FLAG_SYSTEM = 8'h90;

	typedef enum logic [1:0] {
		KIND_RAIN   = 2'd0,
		KIND_SYSTEM = 2'd1,
		KIND_OTHER  = 2'd2,
		KIND_CRCERR = 2'd3
	} frame_kind_t;

	typedef enum logic [4:0] {
		ST_HUNT = 5'b00001,
		ST_FLAG = 5'b00010,
		ST_DLO  = 5'b00100,
		ST_DHI  = 5'b01000,
		ST_CHK  = 5'b10000
	} parse_state_t;

	// msb-first crc-8, one byte, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] value);
		logic [7:0] c;
		c = crc ^ value;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/crc8_checked_sensor_frame_parser.sv =====
// crc8_checked_sensor_frame_parser: hunts for start byte, collects flag, data and crc bytes
// and emits one checked frame result (none for system frames while disabled); depends on crc8sfp_pkg
// The check byte waits in the input register; its result is then registered in the output register.
// Throughput: one input item per cycle; both registers hold while a result waits untaken.
// Reset (arst_n, asynchronous, active low): hunting, crc 0xFF, system status on, no result.
module crc8_checked_sensor_frame_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,  // system_status_enable
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,    // [7:0] rx_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,    // [15:0] frame_value, [23:16] frame_flag, [31:24] computed_crc
	output crc8sfp_pkg::frame_kind_t  m_tuser     // [1:0] frame_kind
);

	import crc8sfp_pkg::*;

	logic         sys_en_q;
	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	parse_state_t state_q;
	logic [7:0]   crc_q;
	logic [7:0]   flag_q;
	logic [7:0]   data_lo_q;
	logic [7:0]   data_hi_q;

	logic         go_s1;
	logic [7:0]   crc_next;
	logic         emit;
	frame_kind_t  kind;
	logic [15:0]  value;

	assign go_s1    = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || go_s1;
	assign crc_next = crc8_update(crc_q, rx_byte_s1);

	// result decision on the check byte
	always_comb begin
		emit  = 1'b0;
		kind  = KIND_OTHER;
		value = {data_hi_q, data_lo_q};
		if (state_q == ST_CHK) begin
			emit = 1'b1;
			priority if (crc_q != rx_byte_s1) begin
				kind = KIND_CRCERR;
			end else if (flag_q == FLAG_RAIN) begin
				kind  = KIND_RAIN;
				value = {8'h00, data_lo_q};
			end else if (flag_q == FLAG_SYSTEM) begin
				kind = KIND_SYSTEM;
				emit = sys_en_q;
			end else begin
				kind = KIND_OTHER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_en_q <= 1'b1;
		end else if (cfg_we) begin
			sys_en_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// frame position and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			crc_q   <= CRC_INIT;
		end else if (go_s1) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte_s1 == START_BYTE) begin
						state_q <= ST_FLAG;
						crc_q   <= CRC_INIT;
					end
				end
				ST_FLAG: begin
					state_q <= ST_DLO;
					crc_q   <= crc_next;
				end
				ST_DLO: begin
					state_q <= ST_DHI;
					crc_q   <= crc_next;
				end
				ST_DHI: begin
					state_q <= ST_CHK;
					crc_q   <= crc_next;
				end
				ST_CHK: begin
					state_q <= ST_HUNT;
					crc_q   <= CRC_INIT;
				end
				default: begin
					state_q <= ST_HUNT;
					crc_q   <= CRC_INIT;
				end
			endcase
		end
	end

	// payload bytes
	always_ff @(posedge clk) begin
		if (go_s1) begin
			if (state_q == ST_FLAG) begin
				flag_q <= rx_byte_s1;
			end
			if (state_q == ST_DLO) begin
				data_lo_q <= rx_byte_s1;
			end
			if (state_q == ST_DHI) begin
				data_hi_q <= rx_byte_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (go_s1 && emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			m_tdata <= {crc_q, flag_q, value};
			m_tuser <= kind;
		end
	end

`ifndef ASSERT_OFF
	a_chk_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && state_q == ST_CHK |=> state_q == ST_HUNT)
		else $error("parser did not return to hunting after the check byte");

	a_result_only_from_chk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_CHK) && $past(go_s1))
		else $error("result raised without a completed frame");

	a_rain_high_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_RAIN |-> m_tdata[15:8] == 8'h00 && m_tdata[23:16] == FLAG_RAIN)
		else $error("rain result carries a high data byte or wrong flag");

	a_no_accept_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while both registers are blocked");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for crc8_checked_sensor_frame_parser, byte stream in, frame results out
// tracks the frame parse and crc-8 locally and checks every result; needs crc8sfp_pkg and the parser
module tb_top;
	import crc8sfp_pkg::*;

	typedef struct {
		frame_kind_t kind;
		logic [15:0] value;
		logic [7:0]  flag;
		logic [7:0]  crc;
	} frame_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;  // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;            // [15:0] frame_value, [23:16] frame_flag, [31:24] computed_crc
	frame_kind_t m_tuser;            // [1:0] frame_kind

	// local copy of the parser state
	int            rx_pos = 0;
	logic [7:0]    rx_payload [3];
	logic [7:0]    rx_crc = CRC_INIT;
	bit            status_en = 1'b1;
	frame_result_t frames_due [$];
	int            mismatch_count = 0;
	bit            no_gaps = 1'b0;

	crc8_checked_sensor_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// msb first, one message bit at a time
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic track_rx_byte(input logic [7:0] b);
		frame_result_t r;
		bit            emit;
		emit = 1'b0;
		case (rx_pos)
			1, 2, 3: begin
				rx_payload[rx_pos - 1] = b;
				rx_crc = crc8_step(rx_crc, b);
				rx_pos++;
			end
			4: begin
				rx_pos  = 0;
				r.flag  = rx_payload[0];
				r.value = {rx_payload[2], rx_payload[1]};
				r.crc   = rx_crc;
				rx_crc  = CRC_INIT;
				emit    = 1'b1;
				if (r.crc != b) begin
					r.kind = KIND_CRCERR;
				end else if (r.flag == FLAG_RAIN) begin
					r.kind  = KIND_RAIN;
					r.value = {8'h00, rx_payload[1]};
				end else if (r.flag == FLAG_SYSTEM) begin
					r.kind = KIND_SYSTEM;
					emit   = status_en;
				end else begin
					r.kind = KIND_OTHER;
				end
			end
			default: begin
				rx_pos = 0;
				if (b == START_BYTE) begin
					rx_crc = CRC_INIT;
					rx_pos = 1;
				end
			end
		endcase
		if (emit) begin
			frames_due.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata %h tuser %0d", m_tdata, m_tuser));
			end else begin
				want = frames_due.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
				if (m_tdata[15:0] !== want.value)
					report_mismatch($sformatf("value %h, want %h", m_tdata[15:0], want.value));
				if (m_tdata[23:16] !== want.flag)
					report_mismatch($sformatf("flag %h, want %h", m_tdata[23:16], want.flag));
				if (m_tdata[31:24] !== want.crc)
					report_mismatch($sformatf("crc %h, want %h", m_tdata[31:24], want.crc));
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 38);
	end

	task automatic send_byte(input logic [7:0] b);
		while (!no_gaps && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		track_rx_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] flag, input logic [7:0] lo,
			input logic [7:0] hi, input bit corrupt);
		logic [7:0] chk;
		chk = crc8_step(crc8_step(crc8_step(CRC_INIT, flag), lo), hi);
		if (corrupt) begin
			chk = chk ^ 8'($urandom_range(1, 255));
		end
		send_byte(START_BYTE);
		send_byte(flag);
		send_byte(lo);
		send_byte(hi);
		send_byte(chk);
	endtask

	// also lets the pipeline empty of items that give no result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_status_enable(input bit en);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		status_en = en;
		cfg_we    <= 1'b0;
	endtask

	task automatic random_frames(input int n_items);
		int         sent;
		int         pick;
		int         n_tail;
		logic [7:0] flag;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_byte(8'($urandom_range(255)));
				sent += 1;
			end else if (pick < 14) begin
				// frame cut short, the next bytes fill it up
				n_tail = $urandom_range(1, 3);
				send_byte(START_BYTE);
				repeat (n_tail) send_byte(8'($urandom_range(255)));
				sent += n_tail + 1;
			end else begin
				case ($urandom_range(3))
					0:       flag = FLAG_RAIN;
					1:       flag = FLAG_SYSTEM;
					default: flag = 8'($urandom_range(255));
				endcase
				send_frame(flag, 8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(9) == 0);
				sent += 5;
			end
		end
	endtask

	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h3B);
		send_frame(FLAG_RAIN, 8'hA5, 8'hFF, 1'b0);
		send_frame(FLAG_SYSTEM, 8'h00, 8'h80, 1'b0);
		send_frame(START_BYTE, START_BYTE, START_BYTE, 1'b0);
		send_frame(FLAG_RAIN, 8'hFF, 8'h00, 1'b1);
	endtask

	task automatic test_status_enable();
		write_status_enable(1'b0);
		send_frame(FLAG_SYSTEM, 8'hFF, 8'hFF, 1'b0);
		send_frame(FLAG_SYSTEM, 8'h12, 8'h34, 1'b1);
		send_frame(8'h91, 8'h5A, 8'hC3, 1'b0);
		write_status_enable(1'b1);
		send_frame(FLAG_SYSTEM, 8'h12, 8'h34, 1'b0);
	endtask

	task automatic test_no_idle_stretch();
		no_gaps = 1'b1;
		random_frames(150);
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			random_frames(10);
			wait_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_status_enable();
		random_frames(250);
		write_status_enable(1'b0);
		random_frames(200);
		test_no_idle_stretch();
		test_drain_pause();
		write_status_enable(1'b1);
		random_frames(200);
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
